// File: rtl/core/cisk_pkg.sv
// ----------------------------------------------------------------------------
// cisk_pkg
// shared widths, modulus and modular add for the increasing subsequence counter
// ----------------------------------------------------------------------------
package cisk_pkg;

    localparam int unsigned CNT_W = 23;
    localparam int unsigned VAL_W = 10;
    localparam int unsigned CFG_W = 7;

    localparam logic [CNT_W-1:0] MODULUS = 23'd5000000;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [CFG_W-1:0] t_cfg;

    // both operands below the modulus
    function automatic t_cnt mod_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        logic [CNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, MODULUS};
        if (s >= {1'b0, MODULUS}) begin
            return d[CNT_W-1:0];
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

// File: rtl/core/cisk_if.sv
// ----------------------------------------------------------------------------
// cisk_in_if / cisk_out_if
// valid/ready channels for input and result transactions
// ----------------------------------------------------------------------------
interface cisk_in_if;
    logic              valid;
    logic              ready;
    cisk_pkg::t_val    value;
    logic              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface cisk_out_if;
    logic              valid;
    logic              ready;
    cisk_pkg::t_cnt    count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

// File: rtl/core/cisk_ram.sv
// ----------------------------------------------------------------------------
// cisk_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cisk_ram #(
    parameter int unsigned AW = 16,
    parameter int unsigned DW = 23
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/count_increasing_subsequences_k_unit.sv
// per transaction, the tree walk of each level runs through the single read port
//   of the count memory
// transactions: one at a time; a finished result waits in S_FIN while the previous
//   result is still held on o_out
// reset and after a last transaction: a clearing pass writes every memory entry,
//   all 2**(ceil(log2(MAX_LEN)) + ceil(log2(VALUE_RANGE))) of them (65536 by default), input not ready
// ----------------------------------------------------------------------------
// count_increasing_subsequences_k_unit
// counts strictly increasing subsequences of length k with one prefix-sum
// tree per length held in a single memory
// ----------------------------------------------------------------------------
module count_increasing_subsequences_k_unit #(
    parameter int unsigned MAX_LEN     = 64,
    parameter int unsigned VALUE_RANGE = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  cisk_pkg::t_cfg        i_cfg_wdata,
    cisk_in_if.sink               i_in,
    cisk_out_if.source            o_out
);
    import cisk_pkg::*;

    localparam int unsigned LW = $clog2(MAX_LEN);
    localparam int unsigned VW = $clog2(VALUE_RANGE);
    localparam int unsigned PW = VW + 2;
    localparam int unsigned AW = LW + VW;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_QRY, S_QDRAIN, S_UPD_RD, S_UPD_WR, S_FIN
    } t_state;

    t_state          r_state;
    t_cfg            r_k;
    logic [PW-1:0]   r_v;
    logic            r_last;
    logic [LW-1:0]   r_lvl;
    logic [LW-1:0]   r_kl;
    logic [PW-1:0]   r_pos;
    logic            r_qv;
    t_cnt            r_acc;
    t_cnt            r_add;
    t_cnt            r_top;
    t_cnt            r_total;
    logic [AW-1:0]   r_clr;
    logic            r_ov;
    t_cnt            r_count;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_cnt            mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_cnt            mem_rdata;

    logic [PW-1:0]   low_bit;
    logic [PW-1:0]   pos_dn;
    logic [PW-1:0]   pos_up;
    logic [PW-1:0]   pos_m1;
    logic [LW-1:0]   lvl_m1;
    logic [31:0]     v_sat;
    logic [8:0]      k_cl;
    t_cnt            total_n;
    logic            out_free;

    cisk_ram #(.AW(AW), .DW(CNT_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign low_bit  = r_pos & (~r_pos + PW'(1));
    assign pos_dn   = r_pos - low_bit;
    assign pos_up   = r_pos + low_bit;
    assign pos_m1   = r_pos - PW'(1);
    assign lvl_m1   = r_lvl - LW'(1);
    assign total_n  = mod_add(r_total, r_top);
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        v_sat = {{(32-VAL_W){1'b0}}, i_in.value};
        if (v_sat >= 32'(VALUE_RANGE)) begin
            v_sat = 32'(VALUE_RANGE) - 32'd1;
        end
        k_cl = {2'b0, r_k};
        if (k_cl == 9'd0) begin
            k_cl = 9'd1;
        end
        if (k_cl > 9'(MAX_LEN)) begin
            k_cl = 9'(MAX_LEN);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_lvl, pos_m1[VW-1:0]};
        mem_wdata = mod_add(mem_rdata, r_add);
        mem_raddr = {r_lvl, pos_m1[VW-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_QRY: begin
                mem_raddr = {lvl_m1, pos_m1[VW-1:0]};
            end
            S_UPD_WR: begin
                mem_we    = 1'b1;
                mem_raddr = {r_lvl, pos_up[VW-1:0] - VW'(1)};
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= t_cfg'(1);
            r_clr   <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_qv    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
            if (r_ov && o_out.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            r_qv <= (r_state == S_QRY);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_v     <= v_sat[PW-1:0];
                        r_pos   <= v_sat[PW-1:0] + PW'(1);
                        r_last  <= i_in.last;
                        r_lvl   <= '0;
                        r_kl    <= LW'(k_cl - 9'd1);
                        r_add   <= t_cnt'(1);
                        r_top   <= '0;
                        r_state <= S_UPD_RD;
                    end
                end
                S_QRY: begin
                    r_pos <= pos_dn;
                    if (r_qv) begin
                        r_acc <= mod_add(r_acc, mem_rdata);
                    end
                    if (pos_dn == '0) begin
                        r_state <= S_QDRAIN;
                    end
                end
                S_QDRAIN: begin
                    r_add   <= mod_add(r_acc, mem_rdata);
                    r_pos   <= r_v + PW'(1);
                    r_state <= S_UPD_RD;
                end
                S_UPD_RD: begin
                    if (r_lvl == r_kl) begin
                        r_top <= r_add;
                    end
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    if (pos_up > PW'(VALUE_RANGE)) begin
                        r_acc <= '0;
                        r_lvl <= r_lvl + LW'(1);
                        if (r_lvl == LW'(MAX_LEN - 1)) begin
                            r_state <= S_FIN;
                        end else if (r_v == '0) begin
                            r_add   <= '0;
                            r_pos   <= PW'(1);
                            r_state <= S_UPD_RD;
                        end else begin
                            r_pos   <= r_v;
                            r_state <= S_QRY;
                        end
                    end else begin
                        r_pos <= pos_up;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_count <= total_n;
                        if (r_last) begin
                            r_total <= '0;
                            r_clr   <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_total <= total_n;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/cisk_checker.sv
// ----------------------------------------------------------------------------
// cisk_checker
// port-level checks for the increasing subsequence counter
// ----------------------------------------------------------------------------
module cisk_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input cisk_pkg::t_cnt i_out_count
);
    import cisk_pkg::*;

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // clearing pass after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("ready right after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count < MODULUS))
        else $error("count above modulus");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_count)))
        else $error("result dropped while stalled");

endmodule

bind count_increasing_subsequences_k_unit cisk_checker u_cisk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_count (o_out.count)
);

// File: tb/tb_count_increasing_subsequences_k_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_count_increasing_subsequences_k_unit
// drives value/last transactions through the increasing subsequence counter,
// first from a directed table, then in random sequences closed by a last
// transaction; each result is compared with the table's count on checked rows, else with a local prefix-sum predictor
// ----------------------------------------------------------------------------
module tb_count_increasing_subsequences_k_unit;
    import cisk_pkg::*;

    localparam int unsigned LEVELS   = 64;
    localparam int unsigned VALUES   = 1024;
    localparam int unsigned WD_LIMIT = 200000;
    localparam int unsigned SEQ_LEN  = 150;

    typedef struct {
        logic       do_cfg;
        t_cfg       cfg;
        t_val       value;
        logic       last;
        logic       chk;
        t_cnt       count;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg i_cfg_wdata;

    cisk_in_if  in_ch ();
    cisk_out_if out_ch ();

    count_increasing_subsequences_k_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_cnt        level_counts [LEVELS][VALUES];
    t_cnt        total_count;
    t_cfg        len_reg;
    t_cnt        count_q [$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    logic        hold_req;
    t_row        rows [17];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_counts();
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < VALUES; i++) begin
                level_counts[l][i] = '0;
            end
        end
        total_count = '0;
    endfunction

    function automatic t_cnt count_step(input t_val v, input logic l);
        int unsigned k;
        longint unsigned acc;
        t_cnt add;
        t_cnt top;
        t_cnt res;
        k = 32'(len_reg);
        top = '0;
        if (k == 0) k = 1;
        if (k > LEVELS) k = LEVELS;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if (lvl == 0) begin
                add = 23'd1;
            end else begin
                acc = 0;
                for (int i = 0; i < v; i++) acc += level_counts[lvl-1][i];
                add = t_cnt'(acc % 5000000);
            end
            level_counts[lvl][v] = t_cnt'((32'(level_counts[lvl][v]) + add) % 5000000);
            if (lvl + 1 == k) top = add;
        end
        total_count = t_cnt'((32'(total_count) + top) % 5000000);
        res = total_count;
        if (l) clear_counts();
        return res;
    endfunction

    // one transaction; returns at the accepting edge with valid still high
    task automatic send_item(input t_val v, input logic l, input logic chk, input t_cnt cnt);
        t_cnt pred;
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = count_step(v, l);
        count_q.push_back(chk ? cnt : pred);
    endtask

    task automatic write_len(input t_cfg k);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (count_q.size() != 0) @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        len_reg = k;
        i_cfg_we <= 1'b0;
    endtask

    // receiver stall pattern plus one long hold-off
    initial begin
        int unsigned mode;
        int unsigned left;
        int unsigned hold;
        logic        did_hold;
        mode = 0;
        left = 0;
        hold = 0;
        did_hold = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !did_hold) begin
                did_hold = 1'b1;
                hold = 4000;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(50, 400);
            end
            left--;
            if (hold != 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (mode == 0) begin
                out_ch.ready <= 1'b1;
            end else if (mode == 1) begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (count_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result count=%0d", out_ch.count);
            end else begin
                if (out_ch.count !== count_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("count mismatch: expected %0d actual %0d",
                                 count_q[0], out_ch.count);
                    end
                end
                void'(count_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_val v;
        t_val ramp;
        logic l;
        int unsigned burst;
        rows[0]  = '{1'b0, 7'd0,   10'd0,    1'b0, 1'b1, 23'd1};
        rows[1]  = '{1'b0, 7'd0,   10'd1023, 1'b0, 1'b1, 23'd2};
        rows[2]  = '{1'b0, 7'd0,   10'd5,    1'b0, 1'b1, 23'd3};
        rows[3]  = '{1'b0, 7'd0,   10'd5,    1'b0, 1'b1, 23'd4};
        rows[4]  = '{1'b1, 7'd2,   10'd10,   1'b0, 1'b0, 23'd0};
        rows[5]  = '{1'b0, 7'd0,   10'd1023, 1'b0, 1'b0, 23'd0};
        rows[6]  = '{1'b0, 7'd0,   10'd3,    1'b0, 1'b0, 23'd0};
        rows[7]  = '{1'b1, 7'd0,   10'd500,  1'b0, 1'b0, 23'd0};
        rows[8]  = '{1'b1, 7'd127, 10'd600,  1'b0, 1'b0, 23'd0};
        rows[9]  = '{1'b1, 7'd64,  10'd700,  1'b0, 1'b0, 23'd0};
        rows[10] = '{1'b1, 7'd65,  10'd800,  1'b0, 1'b0, 23'd0};
        rows[11] = '{1'b1, 7'd3,   10'd900,  1'b1, 1'b0, 23'd0};
        rows[12] = '{1'b0, 7'd0,   10'd0,    1'b0, 1'b1, 23'd0};
        rows[13] = '{1'b0, 7'd0,   10'd1,    1'b0, 1'b1, 23'd0};
        rows[14] = '{1'b0, 7'd0,   10'd2,    1'b0, 1'b1, 23'd1};
        rows[15] = '{1'b0, 7'd0,   10'd1023, 1'b0, 1'b0, 23'd0};
        rows[16] = '{1'b1, 7'd1,   10'd1023, 1'b1, 1'b0, 23'd0};

        mismatches  = 0;
        idle_cycles = 0;
        hold_req    = 1'b0;
        len_reg     = 7'd1;
        clear_counts();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.last  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].do_cfg) write_len(rows[r].cfg);
            send_item(rows[r].value, rows[r].last, rows[r].chk, rows[r].count);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_len(t_cfg'($urandom_range(2, 6)));
                1: write_len(7'd64);
                default: write_len(t_cfg'($urandom_range(0, 127)));
            endcase
            if (ph == 1) hold_req = 1'b1;
            ramp = '0;
            burst = 0;
            for (int n = 0; n < SEQ_LEN; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    ramp = ramp + t_val'($urandom_range(0, 12));
                    v = ramp;
                end else begin
                    v = t_val'($urandom_range(0, 1023));
                end
                l = (n == SEQ_LEN - 1);
                send_item(v, l, 1'b0, '0);
                if (burst == 0) begin
                    burst = $urandom_range(1, 8);
                    if ($urandom_range(0, 2) != 0) begin
                        in_ch.valid <= 1'b0;
                        repeat ($urandom_range(1, 4)) @(posedge i_clk);
                    end
                end else begin
                    burst--;
                end
            end
        end

        in_ch.valid <= 1'b0;
        while (count_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/cisk_pkg.sv
rtl/core/cisk_if.sv
rtl/core/cisk_ram.sv
rtl/core/count_increasing_subsequences_k_unit.sv
rtl/core/cisk_checker.sv
tb/tb_count_increasing_subsequences_k_unit.sv
